// ===== rtl/rtas_pkg.sv =====
package rtas_pkg;

  localparam int unsigned MaxCells = 64;
  localparam int unsigned IdxW     = $clog2(MaxCells);

  localparam int unsigned LenW   = 7;
  localparam int unsigned SweepW = 16;
  localparam int unsigned CfgW   = SweepW;

  typedef logic [MaxCells-1:0] cells_t;
  typedef logic [IdxW-1:0]     idx_t;

  // configuration register indexes
  localparam logic CFG_RING_LENGTH = 1'b0;
  localparam logic CFG_SWEEP_COUNT = 1'b1;

  localparam logic [LenW-1:0]   RingLengthRst = LenW'(MaxCells);
  localparam logic [SweepW-1:0] SweepCountRst = SweepW'(1);

endpackage

// ===== rtl/rtas_if.sv =====
interface rtas_in_if;
  logic valid;
  logic ready;
  logic cell_in;

  modport source (output valid, output cell_in, input ready);
  modport sink (input valid, input cell_in, output ready);
endinterface

interface rtas_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic last_cell;

  modport source (output valid, output cell_out, output last_cell, input ready);
  modport sink (input valid, input cell_out, input last_cell, output ready);
endinterface

// ===== rtl/rtas_sweep.sv =====
// One full left-to-right sweep in a single pass. Because a car only moves
// into an empty cell, a cell filled from its left neighbor can never have
// moved itself, so every move except the wrap is independent per lane.
module rtas_sweep
  import rtas_pkg::*;
(
  input  cells_t cells_i,
  input  idx_t   last_i,
  output cells_t cells_o
);

  logic [MaxCells:0] ext;
  cells_t            mv;
  logic              mv0;
  logic              wrap_mv;

  always_comb begin
    ext = {1'b0, cells_i};
    mv0 = (last_i != '0) & cells_i[0] & ~cells_i[1];
    for (int i = 0; i < MaxCells; i++) begin
      if (IdxW'(i) < last_i) begin
        mv[i] = cells_i[i] & ~ext[i+1];
      end else if (IdxW'(i) == last_i && last_i != '0) begin
        // successor is cell 0 as already updated in this sweep
        mv[i] = cells_i[i] & ~(cells_i[0] & ~mv0);
      end else begin
        mv[i] = 1'b0;
      end
    end
    wrap_mv = mv[last_i];
    cells_o[0] = (cells_i[0] & ~mv[0]) | wrap_mv;
    for (int j = 1; j < MaxCells; j++) begin
      cells_o[j] = (cells_i[j] & ~mv[j]) | (mv[j-1] & (IdxW'(j-1) != last_i));
    end
  end

endmodule

// ===== rtl/ring_traffic_automaton_sweeps_unit.sv =====
// Channel   Dir  Payload               Transaction
// in_i      in   cell_in               valid & ready
// out_o     out  cell_out, last_cell   valid & ready
// cfg       in   cfg_idx_i, cfg_data_i cfg_we_i
//
// While the ring loads, in_i.ready stays high and one input cell is taken
// per cycle. Once the ring is complete, the sweep unit applies sweep_count
// full sweeps, one per cycle, then the ring drains one cell per cycle from
// the output register, which back-pressure from out_o.ready stretches.
// Reset clears control state and restores the default configuration; the ring is not cleared.
module ring_traffic_automaton_sweeps_unit
  import rtas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  rtas_in_if.sink           in_i,
  rtas_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [LenW-1:0]   len_cfg_q;
  logic [SweepW-1:0] sweep_cfg_q;
  cells_t            cells_q, cells_d;
  idx_t              pos_q, pos_d;
  idx_t              last_q, last_d;
  logic [SweepW-1:0] cnt_q, cnt_d;
  idx_t              emit_q, emit_d;
  logic              ovalid_q, ovalid_d;
  logic              ocell_q, ocell_d;
  logic              olast_q, olast_d;

  cells_t swept;
  idx_t   cfg_last;
  logic   in_acc;
  logic   slot_free;

  rtas_sweep u_sweep (
    .cells_i (cells_q),
    .last_i  (last_q),
    .cells_o (swept)
  );

  // clamp ring_length to 1..MaxCells, as index of the final cell
  always_comb begin
    if (len_cfg_q == '0) begin
      cfg_last = '0;
    end else if (len_cfg_q > LenW'(MaxCells)) begin
      cfg_last = IdxW'(MaxCells - 1);
    end else begin
      cfg_last = IdxW'(len_cfg_q - LenW'(1));
    end
  end

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid & in_i.ready;
  assign slot_free  = ~ovalid_q | out_o.ready;

  assign out_o.valid     = ovalid_q;
  assign out_o.cell_out  = ocell_q;
  assign out_o.last_cell = olast_q;

  always_comb begin
    state_d  = state_q;
    cells_d  = cells_q;
    pos_d    = pos_q;
    last_d   = last_q;
    cnt_d    = cnt_q;
    emit_d   = emit_q;
    ovalid_d = ovalid_q & ~out_o.ready;
    ocell_d  = ocell_q;
    olast_d  = olast_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          cells_d[pos_q] = in_i.cell_in;
          if (pos_q >= cfg_last) begin
            last_d  = cfg_last;
            cnt_d   = sweep_cfg_q;
            pos_d   = '0;
            state_d = S_SWEEP;
          end else begin
            pos_d = pos_q + IdxW'(1);
          end
        end
      end
      S_SWEEP: begin
        if (cnt_q == '0) begin
          emit_d  = '0;
          state_d = S_EMIT;
        end else begin
          cells_d = swept;
          cnt_d   = cnt_q - SweepW'(1);
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          ocell_d  = cells_q[emit_q];
          olast_d  = (emit_q == last_q);
          if (emit_q == last_q) begin
            state_d = S_LOAD;
          end else begin
            emit_d = emit_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      len_cfg_q   <= RingLengthRst;
      sweep_cfg_q <= SweepCountRst;
      pos_q       <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      ovalid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      last_q   <= last_d;
      cnt_q    <= cnt_d;
      emit_q   <= emit_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RING_LENGTH: len_cfg_q   <= cfg_data_i[LenW-1:0];
          CFG_SWEEP_COUNT: sweep_cfg_q <= cfg_data_i[SweepW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    ocell_q <= ocell_d;
    olast_q <= olast_d;
  end

endmodule

// ===== rtl/rtas_chk.sv =====
module rtas_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell,
  input logic out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_cell) && $stable(out_last))
    else $error("result changed while stalled");

  // loading only stops on a completed ring, i.e. after an accepted cell
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without a transaction");

  // results only start while the ring is being drained, never mid-load
  a_out_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while loading");

endmodule

bind ring_traffic_automaton_sweeps_unit rtas_chk u_rtas_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_cell  (out_o.cell_out),
  .out_last  (out_o.last_cell)
);
